[rtl/core/rgps_pkg.sv]
// ----------------------------------------------------------------------------
// rgps_pkg
// Shared types and constants of the radial glow pixel shader.
// ----------------------------------------------------------------------------
package rgps_pkg;

  localparam int unsigned FRAME_WIDTH  = 320;
  localparam int unsigned FRAME_HEIGHT = 240;

  localparam int unsigned SQ_W      = 28;
  localparam int unsigned RECIP_W   = 21;
  localparam int unsigned DIV_STEPS = RECIP_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [12:0]        HALO_GAP       = 13'd16;
  localparam logic [SQ_W-1:0]    HALO_SQ_RESET  = 28'd256;
  localparam logic [RECIP_W-1:0] RECIP_RESET    = 21'd4096;
  localparam logic [SQ_W-1:0]    RECIP_ONE      = 28'd1048576;
  localparam logic [5:0]         ALPHA_OPAQUE   = 6'd32;
  localparam logic [11:0]        BLEND_ROUND    = 12'd16;

  typedef enum logic [2:0] {
    CfgCenterX    = 3'd0,
    CfgCenterY    = 3'd1,
    CfgCoreRadius = 3'd2,
    CfgHaloRadius = 3'd3,
    CfgGlowColor  = 3'd4,
    CfgCoreAlpha  = 3'd5
  } rgps_cfg_idx_e;

  typedef struct packed {
    logic signed [14:0] center_x;
    logic signed [14:0] center_y;
    logic [15:0]        glow_color;
    logic [5:0]         peak_alpha;
    logic [SQ_W-1:0]    core_sq;
    logic [SQ_W-1:0]    halo_sq;
    logic [RECIP_W-1:0] recip;
  } rgps_cfg_t;

  typedef struct packed {
    logic            valid;
    logic            hit;
    logic            band;
    logic [SQ_W-1:0] diff;
    logic [15:0]     bg;
  } rgps_dist_t;

  typedef struct packed {
    logic        valid;
    logic        written;
    logic [5:0]  alpha;
    logic [15:0] bg;
  } rgps_shade_t;

endpackage

[rtl/core/rgps_derive.sv]
// ----------------------------------------------------------------------------
// rgps_derive
// Configuration registers and the derived radii squares and band reciprocal,
// found by a restoring divider one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgps_derive import rgps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  output rgps_cfg_t   cfg_o,
  output logic        busy_o
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StSquare = 5'b00010,
    StSpan   = 5'b00100,
    StPrep   = 5'b01000,
    StDivide = 5'b10000
  } rgps_div_state_e;

  rgps_div_state_e state_q, state_d;

  logic signed [14:0] center_x_q, center_y_q;
  logic [12:0]        core_r_q, halo_r_q;
  logic [15:0]        color_q;
  logic [5:0]         alpha_q;
  logic               start;

  logic [SQ_W-1:0]    core_sq_q, halo_sq_q, span_q, rem_q;
  logic [RECIP_W-1:0] recip_q, sh_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [13:0]        halo_eff;
  logic [SQ_W-1:0]    num;
  logic [SQ_W:0]      trial;
  logic               qbit;

  always_comb begin
    start = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgCenterX, CfgCenterY, CfgCoreRadius,
        CfgHaloRadius, CfgGlowColor, CfgCoreAlpha: start = 1'b1;
        default: start = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      core_r_q   <= '0;
      halo_r_q   <= HALO_GAP;
      color_q    <= '0;
      alpha_q    <= ALPHA_OPAQUE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgCenterX:    center_x_q <= cfg_wdata_i[14:0];
        CfgCenterY:    center_y_q <= cfg_wdata_i[14:0];
        CfgCoreRadius: core_r_q   <= cfg_wdata_i[12:0];
        CfgHaloRadius: halo_r_q   <= cfg_wdata_i[12:0];
        CfgGlowColor:  color_q    <= cfg_wdata_i;
        CfgCoreAlpha:  alpha_q    <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  assign halo_eff = (halo_r_q <= core_r_q) ? ({1'b0, core_r_q} + {1'b0, HALO_GAP})
                                           : {1'b0, halo_r_q};
  assign num      = RECIP_ONE + span_q - 28'd1;
  assign trial    = {rem_q, sh_q[RECIP_W-1]} - {1'b0, span_q};
  assign qbit     = !trial[SQ_W];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   state_d = StIdle;
      StSquare: state_d = StSpan;
      StSpan:   state_d = StPrep;
      StPrep:   state_d = StDivide;
      StDivide: if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
    if (start) state_d = StSquare;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      core_sq_q <= '0;
      halo_sq_q <= HALO_SQ_RESET;
      recip_q   <= RECIP_RESET;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StSquare) begin
        core_sq_q <= SQ_W'(core_r_q * core_r_q);
        halo_sq_q <= SQ_W'(halo_eff * halo_eff);
      end
      if (state_q == StPrep) begin
        cnt_q <= '0;
      end else if (state_q == StDivide) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) recip_q <= {sh_q[RECIP_W-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StSpan) begin
      span_q <= halo_sq_q - core_sq_q;
    end
    if (state_q == StPrep) begin
      rem_q <= {{RECIP_W{1'b0}}, num[SQ_W-1:RECIP_W]};
      sh_q  <= num[RECIP_W-1:0];
    end else if (state_q == StDivide) begin
      if (qbit) rem_q <= trial[SQ_W-1:0];
      else      rem_q <= {rem_q[SQ_W-2:0], sh_q[RECIP_W-1]};
      sh_q <= {sh_q[RECIP_W-2:0], qbit};
    end
  end

  assign busy_o = (state_q != StIdle);

  assign cfg_o.center_x   = center_x_q;
  assign cfg_o.center_y   = center_y_q;
  assign cfg_o.glow_color = color_q;
  assign cfg_o.peak_alpha = alpha_q;
  assign cfg_o.core_sq    = core_sq_q;
  assign cfg_o.halo_sq    = halo_sq_q;
  assign cfg_o.recip      = recip_q;

endmodule

[rtl/core/rgps_dist.sv]
// ----------------------------------------------------------------------------
// rgps_dist
// Frame check, squared Q4 distance to the glow centre and band selection,
// four register stages.
// ----------------------------------------------------------------------------
module rgps_dist import rgps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  logic [8:0] pixel_x_i,
  input  logic [7:0] pixel_y_i,
  input  logic [15:0] background_i,
  input  rgps_cfg_t  cfg_i,
  output rgps_dist_t dist_o
);

  logic [3:0]         v_q;
  logic [15:0]        bg1_q, bg2_q, bg3_q, bg4_q;
  logic               fr1_q, fr2_q, fr3_q;
  logic signed [16:0] dx_q, dy_q;
  logic [29:0]        sqx_q, sqy_q;
  logic [30:0]        d2_q;
  logic               hit_q, band_q;
  logic [SQ_W-1:0]    diff_q;

  logic [12:0]        px_c, py_c;
  logic signed [16:0] dx, dy;
  logic signed [33:0] sqx, sqy;
  logic               in_frame;

  assign px_c     = {pixel_x_i, 4'b1000};
  assign py_c     = {1'b0, pixel_y_i, 4'b1000};
  assign dx       = $signed({4'b0, px_c}) - $signed({{2{cfg_i.center_x[14]}}, cfg_i.center_x});
  assign dy       = $signed({4'b0, py_c}) - $signed({{2{cfg_i.center_y[14]}}, cfg_i.center_y});
  assign in_frame = ({4'b0, pixel_x_i} < 13'(FRAME_WIDTH)) &&
                    ({5'b0, pixel_y_i} < 13'(FRAME_HEIGHT));
  assign sqx      = dx_q * dx_q;
  assign sqy      = dy_q * dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bg1_q  <= background_i;
      fr1_q  <= in_frame;
      dx_q   <= dx;
      dy_q   <= dy;
      bg2_q  <= bg1_q;
      fr2_q  <= fr1_q;
      sqx_q  <= sqx[29:0];
      sqy_q  <= sqy[29:0];
      bg3_q  <= bg2_q;
      fr3_q  <= fr2_q;
      d2_q   <= {1'b0, sqx_q} + {1'b0, sqy_q};
      bg4_q  <= bg3_q;
      hit_q  <= fr3_q && (d2_q < {3'b0, cfg_i.halo_sq});
      band_q <= d2_q > {3'b0, cfg_i.core_sq};
      diff_q <= cfg_i.halo_sq - d2_q[SQ_W-1:0];
    end
  end

  assign dist_o.valid = v_q[3];
  assign dist_o.hit   = hit_q;
  assign dist_o.band  = band_q;
  assign dist_o.diff  = diff_q;
  assign dist_o.bg    = bg4_q;

endmodule

[rtl/core/rgps_alpha.sv]
// ----------------------------------------------------------------------------
// rgps_alpha
// Halo falloff: band factor through split partial products, its square and
// the scaled, clamped alpha, four register stages.
// ----------------------------------------------------------------------------
module rgps_alpha import rgps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  rgps_dist_t  dist_i,
  input  rgps_cfg_t   cfg_i,
  output rgps_shade_t shade_o
);

  localparam int unsigned HalfW = SQ_W / 2;

  logic [3:0]       v_q;
  logic [2:0]       hit_q, band_q;
  logic [15:0]      bg5_q, bg6_q, bg7_q, bg8_q;
  logic [SQ_W-1:0]  plo_q;
  logic [HalfW-1:0] phi_q;
  logic [15:0]      f_q;
  logic [23:0]      fsq_q;
  logic             wr_q;
  logic [5:0]       alpha_q;

  logic [SQ_W-1:0]  prod;
  logic [31:0]      fsq;
  logic [29:0]      pa;
  logic [21:0]      a_sc;
  logic [5:0]       a_sel;

  assign prod  = plo_q + {phi_q, {HalfW{1'b0}}};
  assign fsq   = f_q * f_q;
  assign pa    = fsq_q * cfg_i.peak_alpha;
  assign a_sc  = pa[29:8];
  assign a_sel = !band_q[2] ? cfg_i.peak_alpha :
                 (a_sc > {16'b0, cfg_i.peak_alpha}) ? cfg_i.peak_alpha : a_sc[5:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], dist_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q   <= SQ_W'(dist_i.diff[HalfW-1:0] * cfg_i.recip);
      phi_q   <= HalfW'(dist_i.diff[SQ_W-1:HalfW] * cfg_i.recip);
      hit_q   <= {hit_q[1:0], dist_i.hit};
      band_q  <= {band_q[1:0], dist_i.band};
      bg5_q   <= dist_i.bg;
      f_q     <= prod[SQ_W-1:12];
      bg6_q   <= bg5_q;
      fsq_q   <= fsq[31:8];
      bg7_q   <= bg6_q;
      alpha_q <= a_sel;
      wr_q    <= hit_q[2] && (a_sel != 6'd0);
      bg8_q   <= bg7_q;
    end
  end

  assign shade_o.valid   = v_q[3];
  assign shade_o.written = wr_q;
  assign shade_o.alpha   = alpha_q;
  assign shade_o.bg      = bg8_q;

endmodule

[rtl/core/rgps_blend.sv]
// ----------------------------------------------------------------------------
// rgps_blend
// Per-channel RGB565 blend of the glow colour over the background and the
// output register of the stream.
// ----------------------------------------------------------------------------
module rgps_blend import rgps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  rgps_shade_t shade_i,
  input  logic [15:0] glow_color_i,
  output logic        valid_o,
  output logic [15:0] pixel_o,
  output logic        written_o
);

  logic        valid_q, written_q;
  logic [15:0] pixel_q, mixed;
  logic [5:0]  inv;
  logic [11:0] r_sum, g_sum, b_sum;

  assign inv   = ALPHA_OPAQUE - shade_i.alpha;
  assign r_sum = 12'(glow_color_i[15:11] * shade_i.alpha) +
                 12'(shade_i.bg[15:11] * inv) + BLEND_ROUND;
  assign g_sum = 12'(glow_color_i[10:5] * shade_i.alpha) +
                 12'(shade_i.bg[10:5] * inv) + BLEND_ROUND;
  assign b_sum = 12'(glow_color_i[4:0] * shade_i.alpha) +
                 12'(shade_i.bg[4:0] * inv) + BLEND_ROUND;

  always_comb begin
    priority if (!shade_i.written) begin
      mixed = shade_i.bg;
    end else if (shade_i.alpha >= ALPHA_OPAQUE) begin
      mixed = glow_color_i;
    end else begin
      mixed = {r_sum[9:5], g_sum[10:5], b_sum[9:5]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= shade_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pixel_q   <= mixed;
      written_q <= shade_i.written;
    end
  end

  assign valid_o   = valid_q;
  assign pixel_o   = pixel_q;
  assign written_o = written_q;

endmodule

[rtl/core/radial_glow_pixel_shader_core.sv]
// An accepted item passes the distance stages, the alpha stages and the blend output register.
// Throughput: one item per cycle through the nine-stage pixel pipeline when not stalled.
// A configuration write holds off input while the squares and the
// band reciprocal are rebuilt; the divider retires one quotient bit per cycle.
// Reset is asynchronous and active low; it loads the reset configuration and its
// derived values at once, so input is taken from the first cycle after reset.
// ----------------------------------------------------------------------------
// radial_glow_pixel_shader_core
// Radial glow shader: blends a soft circular glow over an RGB565 pixel stream.
// ----------------------------------------------------------------------------
module radial_glow_pixel_shader_core import rgps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pixel_x[8:0], pixel_y[16:9], background[32:17]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // pixel_out[15:0]
  output logic        m_axis_tuser    // was_written
);

  rgps_cfg_t   cfg;
  rgps_dist_t  dist_res;
  rgps_shade_t shade;
  logic        busy, en;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !busy;

  rgps_derive u_derive (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .busy_o      (busy)
  );

  rgps_dist u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (s_axis_tvalid && s_axis_tready),
    .pixel_x_i    (s_axis_tdata[8:0]),
    .pixel_y_i    (s_axis_tdata[16:9]),
    .background_i (s_axis_tdata[32:17]),
    .cfg_i        (cfg),
    .dist_o       (dist_res)
  );

  rgps_alpha u_alpha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .dist_i  (dist_res),
    .cfg_i   (cfg),
    .shade_o (shade)
  );

  rgps_blend u_blend (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .shade_i      (shade),
    .glow_color_i (cfg.glow_color),
    .valid_o      (m_axis_tvalid),
    .pixel_o      (m_axis_tdata),
    .written_o    (m_axis_tuser)
  );

endmodule

[rtl/core/rgps_checker.sv]
// ----------------------------------------------------------------------------
// rgps_checker
// Port-level checks of the glow shader: stream hold rules, input hold-off
// after configuration and the pipeline latency.
// ----------------------------------------------------------------------------
module rgps_checker import rgps_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_index_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Output item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Output item changed while stalled.");

  a_cfg_holdoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_index_i <= CfgCoreAlpha) |=> !s_axis_tready)
    else $error("Input taken while derived values are rebuilt.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("Result missing after the pipeline latency.");

endmodule

bind radial_glow_pixel_shader_core rgps_checker u_checker (.*);

[bench/rgps_glow_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgps_glow_checker
// Watches the configuration port and both pixel streams of the radial glow
// shader. It keeps its own copy of the glow registers and of the squared radii
// and band reciprocal derived from them. For every accepted input pixel it
// computes the blended pixel, queues it, and compares it, field by field, with
// the results that leave the block, in the same order.
// ----------------------------------------------------------------------------
module rgps_glow_checker import rgps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pixel_x[8:0], pixel_y[16:9], background[32:17]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // pixel_out[15:0]
  input  logic        m_axis_tuser,   // was_written
  output int          pending_o,
  output int          mismatch_count_o
);

  typedef struct packed {
    logic        written;
    logic [15:0] color;
  } shaded_px_t;

  logic signed [14:0] glow_cx;
  logic signed [14:0] glow_cy;
  logic [12:0]        core_r;
  logic [12:0]        halo_r;
  logic [15:0]        glow_rgb;
  logic [5:0]         glow_alpha;

  longint unsigned halo_eff;
  longint unsigned core_sq;
  longint unsigned halo_sq;
  longint unsigned band_span;
  longint unsigned band_recip;

  shaded_px_t blended_q[$];
  shaded_px_t oldest;
  int         mismatches = 0;

  assign mismatch_count_o = mismatches;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glow_cx    <= '0;
      glow_cy    <= '0;
      core_r     <= '0;
      halo_r     <= HALO_GAP;
      glow_rgb   <= '0;
      glow_alpha <= ALPHA_OPAQUE;
    end else if (cfg_we_i) begin
      case (rgps_cfg_idx_e'(cfg_index_i))
        CfgCenterX:    glow_cx    <= cfg_wdata_i[14:0];
        CfgCenterY:    glow_cy    <= cfg_wdata_i[14:0];
        CfgCoreRadius: core_r     <= cfg_wdata_i[12:0];
        CfgHaloRadius: halo_r     <= cfg_wdata_i[12:0];
        CfgGlowColor:  glow_rgb   <= cfg_wdata_i;
        CfgCoreAlpha:  glow_alpha <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // A halo that does not reach past the core is widened to core plus one pixel.
  always_comb begin
    halo_eff   = (halo_r > core_r) ? longint'(halo_r) : longint'(core_r) + longint'(HALO_GAP);
    core_sq    = longint'(core_r) * longint'(core_r);
    halo_sq    = halo_eff * halo_eff;
    band_span  = halo_sq - core_sq;
    band_recip = (longint'(RECIP_ONE) + band_span - 1) / band_span;
  end

  function automatic shaded_px_t shade_pixel(logic [8:0] px, logic [7:0] py, logic [15:0] bg);
    longint          dx;
    longint          dy;
    longint unsigned d2;
    longint unsigned f;
    longint unsigned a;
    longint unsigned inv;
    longint unsigned r;
    longint unsigned g;
    longint unsigned b;
    shaded_px_t      res;
    res.written = 1'b0;
    res.color   = bg;
    if (px >= FRAME_WIDTH || py >= FRAME_HEIGHT) return res;
    dx = longint'(px) * 16 + 8 - longint'(glow_cx);
    dy = longint'(py) * 16 + 8 - longint'(glow_cy);
    d2 = dx * dx + dy * dy;
    if (d2 >= halo_sq) return res;
    a = glow_alpha;
    if (d2 > core_sq) begin
      f = ((halo_sq - d2) * band_recip) >> 12;
      a = (((f * f) >> 8) * glow_alpha) >> 8;
      if (a > glow_alpha) a = glow_alpha;
    end
    if (a == 0) return res;
    res.written = 1'b1;
    if (a >= ALPHA_OPAQUE) begin
      res.color = glow_rgb;
      return res;
    end
    inv = ALPHA_OPAQUE - a;
    r = (glow_rgb[15:11] * a + bg[15:11] * inv + BLEND_ROUND) >> 5;
    g = (glow_rgb[10:5] * a + bg[10:5] * inv + BLEND_ROUND) >> 5;
    b = (glow_rgb[4:0] * a + bg[4:0] * inv + BLEND_ROUND) >> 5;
    res.color = {r[4:0], g[5:0], b[4:0]};
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blended_q.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (blended_q.size() == 0) begin
          $error("unexpected result: pixel_out %h was_written %b", m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          oldest = blended_q.pop_front();
          if (m_axis_tdata !== oldest.color) begin
            $error("pixel_out: expected %h, got %h", oldest.color, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tuser !== oldest.written) begin
            $error("was_written: expected %b, got %b", oldest.written, m_axis_tuser);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        blended_q.push_back(shade_pixel(s_axis_tdata[8:0], s_axis_tdata[16:9],
                                        s_axis_tdata[32:17]));
      end
      pending_o <= blended_q.size();
    end
  end

endmodule

[bench/radial_glow_pixel_shader_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radial_glow_pixel_shader_core_tb
// Drives pixels through the radial glow shader under a series of glow
// settings: a directed pass over the core edge, the halo edge, out-of-frame
// pixels and the alpha corner cases, then random settings with pixels aimed
// mostly at the glow. Both streams stall at random. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module radial_glow_pixel_shader_core_tb import rgps_pkg::*;;

  localparam int STALL_LIMIT = 5000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_index_i   = '0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // pixel_x[8:0], pixel_y[16:9], background[32:17]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // pixel_out[15:0]
  logic        m_axis_tuser;         // was_written
  logic        steady        = 1'b0;

  int pending;
  int mismatch_count;
  int quiet_cycles     = 0;
  int pixels_sent      = 0;
  int glow_pixels      = 0;
  int settings_applied = 0;
  int cur_cx           = 0;
  int cur_cy           = 0;
  int cur_reach        = 1;

  radial_glow_pixel_shader_core u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  rgps_glow_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .pending_o        (pending),
    .mismatch_count_o (mismatch_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 22);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready && m_axis_tuser) glow_pixels++;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("radial_glow_pixel_shader_core_tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_pixel(input int x, input int y, input logic [15:0] bg);
    while (!steady && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, bg, y[7:0], x[8:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input rgps_cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Unused upper bits of each write carry noise; the block must ignore them.
  task automatic apply_glow(input int cx, input int cy, input int core, input int halo,
                            input logic [15:0] color, input int alpha);
    logic [15:0] noise;
    noise = 16'($urandom);
    wait_drained();
    repeat (12) @(posedge clk_i);
    write_reg(CfgCenterX, {noise[15], cx[14:0]});
    write_reg(CfgCenterY, {noise[14], cy[14:0]});
    write_reg(CfgCoreRadius, {noise[15:13], core[12:0]});
    write_reg(CfgHaloRadius, {noise[12:10], halo[12:0]});
    write_reg(CfgGlowColor, color);
    write_reg(CfgCoreAlpha, {noise[9:0], alpha[5:0]});
    cur_cx    = cx >>> 4;
    cur_cy    = cy >>> 4;
    cur_reach = ((halo > core) ? halo : core + 16) / 16 + 2;
    settings_applied++;
  endtask

  task automatic run_random_phase(input int count, input bit pause_midway);
    int cx;
    int cy;
    int core;
    int halo;
    int alpha;
    int roll;
    int px;
    int py;
    if ($urandom_range(99) < 80) begin
      cx = int'($urandom_range(0, 5184)) - 32;
      cy = int'($urandom_range(0, 3904)) - 32;
    end else begin
      cx = int'($urandom_range(0, 32767)) - 16384;
      cy = int'($urandom_range(0, 32767)) - 16384;
    end
    roll = $urandom_range(99);
    if (roll < 70) core = $urandom_range(0, 1600);
    else if (roll < 85) core = 0;
    else core = $urandom_range(0, 8191);
    roll = $urandom_range(99);
    if (roll < 60) halo = (core + int'($urandom_range(1, 2400)) > 8191) ? 8191
                          : core + int'($urandom_range(1, 2400));
    else if (roll < 85) halo = $urandom_range(0, core);
    else halo = $urandom_range(0, 8191);
    roll = $urandom_range(99);
    if (roll < 60) alpha = $urandom_range(1, 32);
    else if (roll < 75) alpha = 32;
    else if (roll < 85) alpha = 0;
    else alpha = $urandom_range(33, 63);
    apply_glow(cx, cy, core, halo, 16'($urandom), alpha);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) wait_drained();
      roll = $urandom_range(99);
      if (roll < 60) begin
        px = cur_cx + int'($urandom_range(0, 2 * cur_reach)) - cur_reach;
        py = cur_cy + int'($urandom_range(0, 2 * cur_reach)) - cur_reach;
        px = (px < 0) ? 0 : (px > 319) ? 319 : px;
        py = (py < 0) ? 0 : (py > 239) ? 239 : py;
      end else if (roll < 90) begin
        px = $urandom_range(0, 319);
        py = $urandom_range(0, 239);
      end else begin
        px = $urandom_range(0, 511);
        py = $urandom_range(0, 255);
      end
      send_pixel(px, py, 16'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a one-pixel halo around the origin.
    send_pixel(0, 0, 16'hffff);
    send_pixel(1, 0, 16'h0000);

    // Core edge, band factor above full scale, fade to zero, halo edge, frame edges.
    apply_glow(2568, 1928, 160, 640, 16'hf81f, 32);
    send_pixel(160, 120, 16'h0000);
    send_pixel(160, 120, 16'hffff);
    send_pixel(170, 120, 16'($urandom));
    send_pixel(171, 120, 16'($urandom));
    send_pixel(185, 120, 16'($urandom));
    send_pixel(199, 120, 16'($urandom));
    send_pixel(200, 120, 16'($urandom));
    send_pixel(0, 0, 16'h1234);
    send_pixel(319, 239, 16'($urandom));
    send_pixel(320, 120, 16'($urandom));
    send_pixel(511, 255, 16'hffff);

    // Halo not larger than the core, with core alpha above opaque.
    apply_glow(2568, 1928, 96, 50, 16'h07e0, 40);
    send_pixel(160, 120, 16'($urandom));
    send_pixel(164, 120, 16'($urandom));
    send_pixel(166, 120, 16'($urandom));
    send_pixel(166, 121, 16'($urandom));

    // Zero core alpha inside a wide halo.
    apply_glow(800, 800, 0, 4000, 16'hffff, 0);
    send_pixel(50, 50, 16'($urandom));
    send_pixel(10, 10, 16'($urandom));

    // Register extremes.
    apply_glow(-16384, 16383, 8191, 0, 16'hffff, 63);
    send_pixel(0, 239, 16'($urandom));
    send_pixel(319, 0, 16'($urandom));
    apply_glow(16383, -16384, 0, 8191, 16'h0000, 32);
    send_pixel(319, 0, 16'($urandom));
    send_pixel(0, 239, 16'($urandom));

    for (int k = 0; k < 12; k++) begin
      run_random_phase(160, k == 7);
      if (k == 3) steady <= 1'b1;
      if (k == 5) steady <= 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("%0d pixels shaded under %0d glow settings, %0d of them blended by the glow",
             pixels_sent, settings_applied, glow_pixels);
    if (mismatch_count == 0) begin
      $display("radial_glow_pixel_shader_core_tb: done, clean");
    end else begin
      $display("radial_glow_pixel_shader_core_tb: done, errors");
    end
    $finish;
  end

endmodule

[radial_glow_pixel_shader_core.f]
rtl/core/rgps_pkg.sv
rtl/core/rgps_derive.sv
rtl/core/rgps_dist.sv
rtl/core/rgps_alpha.sv
rtl/core/rgps_blend.sv
rtl/core/radial_glow_pixel_shader_core.sv
rtl/core/rgps_checker.sv
bench/rgps_glow_checker.sv
bench/radial_glow_pixel_shader_core_tb.sv
